// ===== hw/rtl/afst_pkg.sv =====
package afst_pkg;

    // word geometry
    localparam int W        = 32;
    localparam int FracBits = 16;
    localparam int DivSteps = W;
    localparam int DivLat   = DivSteps + 2;
    localparam int GammaW   = 19;
    localparam int ThrW     = 17;
    localparam int Rows     = 4;

    // fixed point constants
    localparam logic signed [W-1:0] QOne = 32'sd65536;
    localparam logic signed [W-1:0] QTwo = 32'sd131072;
    localparam logic signed [W-1:0] SMax = 32'sh7fffffff;
    localparam logic signed [W-1:0] SMin = 32'sh80000000;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CfgGamma    = 2'd0;
    localparam t_cfg_idx CfgImplicit = 2'd1;
    localparam t_cfg_idx CfgAxisThr  = 2'd2;

    localparam logic [1:0] RowFirst = 2'd0;
    localparam logic [1:0] RowLast  = 2'd3;

    // value with its saturation flag
    typedef struct packed {
        logic                f;
        logic signed [W-1:0] v;
    } t_sres;

    function automatic t_sres sat64(input logic signed [63:0] x);
        t_sres r;
        r.f = 1'b0;
        r.v = x[W-1:0];
        if (x > 64'sh000000007fffffff) begin
            r.f = 1'b1;
            r.v = SMax;
        end else if (x < 64'shffffffff80000000) begin
            r.f = 1'b1;
            r.v = SMin;
        end
        return r;
    endfunction

    // floor(a*b / 2^16), saturated
    function automatic t_sres qmul(input logic signed [W-1:0] a, input logic signed [W-1:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat64(p >>> FracBits);
    endfunction

    function automatic t_sres qadd(input logic signed [W-1:0] a, input logic signed [W-1:0] b);
        return sat64(64'(a) + 64'(b));
    endfunction

    function automatic t_sres qsub(input logic signed [W-1:0] a, input logic signed [W-1:0] b);
        return sat64(64'(a) - 64'(b));
    endfunction

    function automatic t_sres qneg(input logic signed [W-1:0] a);
        return sat64(-64'(a));
    endfunction

    // times 0.5, exact floor
    function automatic logic signed [W-1:0] qhalf(input logic signed [W-1:0] a);
        return a >>> 1;
    endfunction

endpackage

// ===== hw/rtl/axisymmetric_flow_source_term_unit.sv =====
// channel   direction  handshake            payload
// cell in   input      i_valid / o_stall    i_density .. i_cell_volume
// rows out  output     o_valid / i_stall    o_row_index .. o_last_row
// config    input      i_cfg_we             i_cfg_idx, i_cfg_data
//
// a cell enters in any cycle the pipeline moves and reaches the row buffer through
// two 34-stage restoring dividers (one quotient bit per restoring step) and 7 multiply stages
// each cell leaves as four rows on consecutive cycles without i_stall; cells keep entering meanwhile
// synchronous active-low reset clears valid bits and sets configuration to its defaults; no clearing pass
// a stall holds the whole pipeline only when the row buffer is full and a cell waits
module axisymmetric_flow_source_term_unit import afst_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  t_cfg_idx            i_cfg_idx,
    input  logic [GammaW-1:0]   i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [W-1:0] i_density,
    input  logic signed [W-1:0] i_momentum_x,
    input  logic signed [W-1:0] i_momentum_y,
    input  logic signed [W-1:0] i_total_energy,
    input  logic signed [W-1:0] i_radial_coord,
    input  logic [W-2:0]        i_cell_volume,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_row_index,
    output logic signed [W-1:0] o_residual,
    output logic signed [W-1:0] o_jac_col0,
    output logic signed [W-1:0] o_jac_col1,
    output logic signed [W-1:0] o_jac_col2,
    output logic signed [W-1:0] o_jac_col3,
    output logic                o_saturated,
    output logic                o_last_row
);

    typedef logic signed [W-1:0] t_q;

    typedef struct packed {
        logic act;
        t_q   rho, mx, my, en;
    } t_cell;

    typedef struct packed {
        logic act;
        t_q   rho, my, en, s, u, v, res0, mxv, myv, mxu, uv, vv, uu, ve, ge, gv, v2;
        logic [Rows-1:0] fb, fj;
    } t_m1;

    typedef struct packed {
        logic act;
        t_q   rho, my, en, s, u, v, v2, ge, gv, res0, res1, res2, t, j10, j20, q, gve, vv2, guv;
        logic [Rows-1:0] fb, fj;
    } t_m2;

    typedef struct packed {
        logic act;
        t_q   rho, my, en, s, u, v, v2, ge, gv, res0, res1, res2, j10, j20, d, vq, t2, j31, ngve;
        logic [Rows-1:0] fb, fj;
    } t_m3;

    typedef struct packed {
        logic act;
        t_q   rho, my, en, s, u, v, v2, ge, gv, res0, res1, res2, j10, j20, j31, ngve, p, gvq, gt2;
        logic [Rows-1:0] fb, fj;
    } t_m4;

    typedef struct packed {
        logic act;
        t_q   rho, my, s, u, v, v2, gv, res0, res1, res2, j10, j20, j31, hn, j30, j32;
        logic [Rows-1:0] fb, fj;
    } t_m5;

    typedef struct packed {
        logic act;
        t_q   my, s, res0, res1, res2, k10, k11, k12, k20, k22, k30, k31, k32, k33;
        logic [Rows-1:0] fb, fj;
    } t_post;

    typedef struct packed {
        t_post b;
        t_q    hm;
    } t_m6;

    typedef struct packed {
        t_post b;
        t_q    res3;
    } t_m7;

    // configuration
    logic [GammaW-1:0] r_gamma;
    logic              r_implicit;
    logic [ThrW-1:0]   r_thr;
    t_q                g;
    t_q                gm1;

    // pipeline
    logic  adv;
    logic  free;
    logic  r_v1 [DivLat];
    logic  r_v2 [DivLat];
    logic  r_m1_v, r_m2_v, r_m3_v, r_m4_v, r_m5_v, r_m6_v, r_m7_v;
    t_cell r_cell [DivLat];
    t_cell n_cell;
    t_m1   r_m1, n_m1;
    t_m2   r_m2, n_m2;
    t_m3   r_m3, n_m3;
    t_m4   r_m4, n_m4;
    t_m5   r_m5, n_m5;
    t_post r_post [DivLat];
    t_post n_post;
    t_m6   r_m6, n_m6;
    t_m7   r_m7, n_m7;
    t_sres d_u, d_v, d_s, d_e, d_h;

    // row buffer
    logic            r_ov;
    logic [1:0]      r_row;
    t_q              r_res [Rows];
    t_q              r_jac [Rows][Rows];
    logic [Rows-1:0] r_sat;
    t_q              n_res [Rows];
    t_q              n_jac [Rows][Rows];
    logic [Rows-1:0] n_sat;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma    <= GammaW'(91750);
            r_implicit <= 1'b0;
            r_thr      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgGamma:    r_gamma    <= i_cfg_data;
                CfgImplicit: r_implicit <= i_cfg_data[0];
                CfgAxisThr:  r_thr      <= i_cfg_data[ThrW-1:0];
                default:     ;
            endcase
        end
    end

    assign g   = $signed(W'(r_gamma));
    assign gm1 = g - QOne;

    // handshake: move unless a finished cell waits on a busy row buffer
    assign free    = !r_ov || (!i_stall && (r_row == RowLast));
    assign adv     = !r_m7_v || free;
    assign o_stall = !adv;

    // first divider bank
    afst_div u_div_u (.i_clk(i_clk), .i_adv(adv), .i_num(i_momentum_x),
                      .i_den(i_density), .o_quo(d_u));
    afst_div u_div_v (.i_clk(i_clk), .i_adv(adv), .i_num(i_momentum_y),
                      .i_den(i_density), .o_quo(d_v));
    afst_div u_div_s (.i_clk(i_clk), .i_adv(adv), .i_num($signed({1'b0, i_cell_volume})),
                      .i_den(i_radial_coord), .o_quo(d_s));
    afst_div u_div_e (.i_clk(i_clk), .i_adv(adv), .i_num(i_total_energy),
                      .i_den(i_density), .o_quo(d_e));

    // cell word alongside the dividers
    always_comb begin
        n_cell.act = (i_radial_coord > $signed(W'(r_thr)));
        n_cell.rho = i_density;
        n_cell.mx  = i_momentum_x;
        n_cell.my  = i_momentum_y;
        n_cell.en  = i_total_energy;
    end

    // stage m1: products of the quotients
    always_comb begin
        t_sres a_res0, a_mxv, a_myv, a_mxu, a_uv, a_vv, a_uu, a_ve, a_ge, a_gv, a_v2;
        t_cell c;
        c      = r_cell[DivLat-1];
        a_res0 = qmul(d_s.v, c.my);
        a_mxv  = qmul(c.mx, d_v.v);
        a_myv  = qmul(c.my, d_v.v);
        a_mxu  = qmul(c.mx, d_u.v);
        a_uv   = qmul(d_u.v, d_v.v);
        a_vv   = qmul(d_v.v, d_v.v);
        a_uu   = qmul(d_u.v, d_u.v);
        a_ve   = qmul(d_v.v, d_e.v);
        a_ge   = qmul(g, d_e.v);
        a_gv   = qmul(g, d_v.v);
        a_v2   = qmul(QTwo, d_v.v);
        n_m1.act  = c.act;
        n_m1.rho  = c.rho;
        n_m1.my   = c.my;
        n_m1.en   = c.en;
        n_m1.s    = d_s.v;
        n_m1.u    = d_u.v;
        n_m1.v    = d_v.v;
        n_m1.res0 = a_res0.v;
        n_m1.mxv  = a_mxv.v;
        n_m1.myv  = a_myv.v;
        n_m1.mxu  = a_mxu.v;
        n_m1.uv   = a_uv.v;
        n_m1.vv   = a_vv.v;
        n_m1.uu   = a_uu.v;
        n_m1.ve   = a_ve.v;
        n_m1.ge   = a_ge.v;
        n_m1.gv   = a_gv.v;
        n_m1.v2   = a_v2.v;
        n_m1.fb[0] = a_res0.f | d_s.f;
        n_m1.fb[1] = a_mxv.f | d_s.f | d_v.f;
        n_m1.fb[2] = a_myv.f | d_s.f | d_v.f;
        n_m1.fb[3] = a_mxu.f | a_myv.f | d_s.f | d_u.f | d_v.f;
        n_m1.fj[0] = 1'b0;
        n_m1.fj[1] = a_uv.f | d_u.f;
        n_m1.fj[2] = a_vv.f | a_v2.f;
        n_m1.fj[3] = d_e.f | a_uu.f | a_vv.f | a_ve.f | a_uv.f | a_ge.f | a_gv.f;
    end

    // stage m2
    always_comb begin
        t_sres a_res1, a_res2, a_t, a_j10, a_j20, a_q, a_gve, a_vv2, a_guv;
        a_res1 = qmul(r_m1.s, r_m1.mxv);
        a_res2 = qmul(r_m1.s, r_m1.myv);
        a_t    = qadd(r_m1.mxu, r_m1.myv);
        a_j10  = qneg(r_m1.uv);
        a_j20  = qneg(r_m1.vv);
        a_q    = qadd(r_m1.uu, r_m1.vv);
        a_gve  = qmul(g, r_m1.ve);
        a_vv2  = qmul(QTwo, r_m1.vv);
        a_guv  = qmul(gm1, r_m1.uv);
        n_m2.act  = r_m1.act;
        n_m2.rho  = r_m1.rho;
        n_m2.my   = r_m1.my;
        n_m2.en   = r_m1.en;
        n_m2.s    = r_m1.s;
        n_m2.u    = r_m1.u;
        n_m2.v    = r_m1.v;
        n_m2.v2   = r_m1.v2;
        n_m2.ge   = r_m1.ge;
        n_m2.gv   = r_m1.gv;
        n_m2.res0 = r_m1.res0;
        n_m2.res1 = a_res1.v;
        n_m2.res2 = a_res2.v;
        n_m2.t    = a_t.v;
        n_m2.j10  = a_j10.v;
        n_m2.j20  = a_j20.v;
        n_m2.q    = a_q.v;
        n_m2.gve  = a_gve.v;
        n_m2.vv2  = a_vv2.v;
        n_m2.guv  = a_guv.v;
        n_m2.fb   = r_m1.fb | {a_t.f, a_res2.f, a_res1.f, 1'b0};
        n_m2.fj   = r_m1.fj | {a_q.f | a_gve.f | a_vv2.f | a_guv.f, a_j20.f, a_j10.f, 1'b0};
    end

    // stage m3
    always_comb begin
        t_sres a_d, a_vq, a_t2, a_j31, a_ngve;
        a_d    = qsub(r_m2.en, qhalf(r_m2.t));
        a_vq   = qmul(r_m2.v, r_m2.q);
        a_t2   = qadd(r_m2.q, r_m2.vv2);
        a_j31  = qneg(r_m2.guv);
        a_ngve = qneg(r_m2.gve);
        n_m3.act  = r_m2.act;
        n_m3.rho  = r_m2.rho;
        n_m3.my   = r_m2.my;
        n_m3.en   = r_m2.en;
        n_m3.s    = r_m2.s;
        n_m3.u    = r_m2.u;
        n_m3.v    = r_m2.v;
        n_m3.v2   = r_m2.v2;
        n_m3.ge   = r_m2.ge;
        n_m3.gv   = r_m2.gv;
        n_m3.res0 = r_m2.res0;
        n_m3.res1 = r_m2.res1;
        n_m3.res2 = r_m2.res2;
        n_m3.j10  = r_m2.j10;
        n_m3.j20  = r_m2.j20;
        n_m3.d    = a_d.v;
        n_m3.vq   = a_vq.v;
        n_m3.t2   = a_t2.v;
        n_m3.j31  = a_j31.v;
        n_m3.ngve = a_ngve.v;
        n_m3.fb   = r_m2.fb | {a_d.f, 3'b000};
        n_m3.fj   = r_m2.fj | {a_vq.f | a_t2.f | a_j31.f | a_ngve.f, 3'b000};
    end

    // stage m4: pressure and the gamma-1 products
    always_comb begin
        t_sres a_p, a_gvq, a_gt2;
        a_p   = qmul(gm1, r_m3.d);
        a_gvq = qmul(gm1, r_m3.vq);
        a_gt2 = qmul(gm1, r_m3.t2);
        n_m4.act  = r_m3.act;
        n_m4.rho  = r_m3.rho;
        n_m4.my   = r_m3.my;
        n_m4.en   = r_m3.en;
        n_m4.s    = r_m3.s;
        n_m4.u    = r_m3.u;
        n_m4.v    = r_m3.v;
        n_m4.v2   = r_m3.v2;
        n_m4.ge   = r_m3.ge;
        n_m4.gv   = r_m3.gv;
        n_m4.res0 = r_m3.res0;
        n_m4.res1 = r_m3.res1;
        n_m4.res2 = r_m3.res2;
        n_m4.j10  = r_m3.j10;
        n_m4.j20  = r_m3.j20;
        n_m4.j31  = r_m3.j31;
        n_m4.ngve = r_m3.ngve;
        n_m4.p    = a_p.v;
        n_m4.gvq  = a_gvq.v;
        n_m4.gt2  = a_gt2.v;
        n_m4.fb   = r_m3.fb | {a_p.f, 3'b000};
        n_m4.fj   = r_m3.fj | {a_gvq.f | a_gt2.f, 3'b000};
    end

    // stage m5: enthalpy numerator and last energy-row entries
    always_comb begin
        t_sres a_hn, a_j30, a_j32;
        a_hn  = qadd(r_m4.en, r_m4.p);
        a_j30 = qadd(r_m4.ngve, r_m4.gvq);
        a_j32 = qsub(r_m4.ge, qhalf(r_m4.gt2));
        n_m5.act  = r_m4.act;
        n_m5.rho  = r_m4.rho;
        n_m5.my   = r_m4.my;
        n_m5.s    = r_m4.s;
        n_m5.u    = r_m4.u;
        n_m5.v    = r_m4.v;
        n_m5.v2   = r_m4.v2;
        n_m5.gv   = r_m4.gv;
        n_m5.res0 = r_m4.res0;
        n_m5.res1 = r_m4.res1;
        n_m5.res2 = r_m4.res2;
        n_m5.j10  = r_m4.j10;
        n_m5.j20  = r_m4.j20;
        n_m5.j31  = r_m4.j31;
        n_m5.hn   = a_hn.v;
        n_m5.j30  = a_j30.v;
        n_m5.j32  = a_j32.v;
        n_m5.fb   = r_m4.fb | {a_hn.f, 3'b000};
        n_m5.fj   = r_m4.fj | {a_j30.f | a_j32.f, 3'b000};
    end

    // second divider: enthalpy
    afst_div u_div_h (.i_clk(i_clk), .i_adv(adv), .i_num(r_m5.hn),
                      .i_den(r_m5.rho), .o_quo(d_h));

    // jacobian scaling by s, then carried beside the enthalpy divider
    always_comb begin
        t_sres a10, a11, a12, a20, a22, a30, a31, a32, a33;
        a10 = qmul(r_m5.j10, r_m5.s);
        a11 = qmul(r_m5.v, r_m5.s);
        a12 = qmul(r_m5.u, r_m5.s);
        a20 = qmul(r_m5.j20, r_m5.s);
        a22 = qmul(r_m5.v2, r_m5.s);
        a30 = qmul(r_m5.j30, r_m5.s);
        a31 = qmul(r_m5.j31, r_m5.s);
        a32 = qmul(r_m5.j32, r_m5.s);
        a33 = qmul(r_m5.gv, r_m5.s);
        n_post.act  = r_m5.act;
        n_post.my   = r_m5.my;
        n_post.s    = r_m5.s;
        n_post.res0 = r_m5.res0;
        n_post.res1 = r_m5.res1;
        n_post.res2 = r_m5.res2;
        n_post.k10  = a10.v;
        n_post.k11  = a11.v;
        n_post.k12  = a12.v;
        n_post.k20  = a20.v;
        n_post.k22  = a22.v;
        n_post.k30  = a30.v;
        n_post.k31  = a31.v;
        n_post.k32  = a32.v;
        n_post.k33  = a33.v;
        n_post.fb   = r_m5.fb;
        n_post.fj   = r_m5.fj | {a30.f | a31.f | a32.f | a33.f, a20.f | a22.f,
                                 a10.f | a11.f | a12.f, 1'b0};
    end

    // stage m6: h times y momentum
    always_comb begin
        t_sres a_hm;
        a_hm    = qmul(d_h.v, r_post[DivLat-1].my);
        n_m6.b  = r_post[DivLat-1];
        n_m6.hm = a_hm.v;
        n_m6.b.fb[3] = r_post[DivLat-1].fb[3] | d_h.f | a_hm.f;
    end

    // stage m7: energy residual
    always_comb begin
        t_sres a_r3;
        a_r3      = qmul(r_m6.b.s, r_m6.hm);
        n_m7.b    = r_m6.b;
        n_m7.res3 = a_r3.v;
        n_m7.b.fb[3] = r_m6.b.fb[3] | a_r3.f;
    end

    // row buffer load: axis and implicit masking
    always_comb begin
        t_post b;
        b = r_m7.b;
        n_res[0] = b.res0;
        n_res[1] = b.res1;
        n_res[2] = b.res2;
        n_res[3] = r_m7.res3;
        for (int k = 0; k < Rows; k++) begin
            for (int c = 0; c < Rows; c++) begin
                n_jac[k][c] = '0;
            end
        end
        if (r_implicit) begin
            n_jac[0][2] = b.s;
            n_jac[1][0] = b.k10;
            n_jac[1][1] = b.k11;
            n_jac[1][2] = b.k12;
            n_jac[2][0] = b.k20;
            n_jac[2][2] = b.k22;
            n_jac[3][0] = b.k30;
            n_jac[3][1] = b.k31;
            n_jac[3][2] = b.k32;
            n_jac[3][3] = b.k33;
        end
        n_sat = b.fb | (r_implicit ? b.fj : '0);
        if (!b.act) begin
            for (int k = 0; k < Rows; k++) begin
                n_res[k] = '0;
                for (int c = 0; c < Rows; c++) begin
                    n_jac[k][c] = '0;
                end
            end
            n_sat = '0;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DivLat; k++) begin
                r_v1[k] <= 1'b0;
                r_v2[k] <= 1'b0;
            end
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_m3_v <= 1'b0;
            r_m4_v <= 1'b0;
            r_m5_v <= 1'b0;
            r_m6_v <= 1'b0;
            r_m7_v <= 1'b0;
        end else if (adv) begin
            r_v1[0] <= i_valid;
            r_v2[0] <= r_m5_v;
            for (int k = 1; k < DivLat; k++) begin
                r_v1[k] <= r_v1[k-1];
                r_v2[k] <= r_v2[k-1];
            end
            r_m1_v <= r_v1[DivLat-1];
            r_m2_v <= r_m1_v;
            r_m3_v <= r_m2_v;
            r_m4_v <= r_m3_v;
            r_m5_v <= r_m4_v;
            r_m6_v <= r_v2[DivLat-1];
            r_m7_v <= r_m6_v;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cell[0] <= n_cell;
            r_post[0] <= n_post;
            for (int k = 1; k < DivLat; k++) begin
                r_cell[k] <= r_cell[k-1];
                r_post[k] <= r_post[k-1];
            end
            r_m1 <= n_m1;
            r_m2 <= n_m2;
            r_m3 <= n_m3;
            r_m4 <= n_m4;
            r_m5 <= n_m5;
            r_m6 <= n_m6;
            r_m7 <= n_m7;
        end
    end

    // row sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_row <= RowFirst;
        end else if (free) begin
            r_ov  <= r_m7_v;
            r_row <= RowFirst;
        end else if (!i_stall) begin
            r_row <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free && r_m7_v) begin
            r_res <= n_res;
            r_jac <= n_jac;
            r_sat <= n_sat;
        end
    end

    // output word
    assign o_valid     = r_ov;
    assign o_row_index = r_row;
    assign o_residual  = r_res[r_row];
    assign o_jac_col0  = r_jac[r_row][0];
    assign o_jac_col1  = r_jac[r_row][1];
    assign o_jac_col2  = r_jac[r_row][2];
    assign o_jac_col3  = r_jac[r_row][3];
    assign o_saturated = r_sat[r_row];
    assign o_last_row  = (r_row == RowLast);

`ifndef ASSERT_OFF
    a_row_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_row |=>
            o_valid && (o_row_index == $past(o_row_index) + 2'd1))
        else $error("row sequence broken");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_m7_v && r_ov && !(!i_stall && o_last_row))
        else $error("stall without a waiting cell");

    a_mass_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_row_index == RowFirst) |->
            (o_jac_col0 == '0) && (o_jac_col1 == '0) && (o_jac_col3 == '0))
        else $error("mass row jacobian has stray entries");
`endif

endmodule

// ===== hw/rtl/afst_div.sv =====
module afst_div import afst_pkg::*; (
    input  logic                i_clk,
    input  logic                i_adv,
    input  logic signed [W-1:0] i_num,
    input  logic signed [W-1:0] i_den,
    output t_sres               o_quo
);

    typedef struct packed {
        logic         den0;
        logic         npos;
        logic         nneg;
        logic         neg;
        logic         big;
        logic [W-1:0] rem;
        logic [W-1:0] dsh;
        logic [W-1:0] mb;
        logic [W-1:0] q;
    } t_dstage;

    t_dstage r_st [DivSteps+1];
    t_dstage n_st [DivSteps+1];
    t_sres   r_quo;
    t_sres   n_quo;

    // magnitudes, overflow precheck and one restoring step per stage
    always_comb begin
        logic [W-1:0] ma;
        logic [W-1:0] mb;
        logic [W:0]   rem2;
        logic [W-1:0] qf;
        ma = i_num[W-1] ? W'(-i_num) : W'(i_num);
        mb = i_den[W-1] ? W'(-i_den) : W'(i_den);
        n_st[0].den0 = (i_den == '0);
        n_st[0].npos = !i_num[W-1] && (i_num != '0);
        n_st[0].nneg = i_num[W-1];
        n_st[0].neg  = i_num[W-1] ^ i_den[W-1];
        n_st[0].big  = (W'(ma[W-1:FracBits]) >= mb);
        n_st[0].rem  = W'(ma[W-1:FracBits]);
        n_st[0].dsh  = {ma[FracBits-1:0], {(W-FracBits){1'b0}}};
        n_st[0].mb   = mb;
        n_st[0].q    = '0;
        for (int k = 0; k < DivSteps; k++) begin
            n_st[k+1] = r_st[k];
            rem2 = {r_st[k].rem, r_st[k].dsh[W-1]};
            n_st[k+1].dsh = {r_st[k].dsh[W-2:0], 1'b0};
            if (rem2 >= {1'b0, r_st[k].mb}) begin
                n_st[k+1].rem = W'(rem2 - {1'b0, r_st[k].mb});
                n_st[k+1].q   = {r_st[k].q[W-2:0], 1'b1};
            end else begin
                n_st[k+1].rem = rem2[W-1:0];
                n_st[k+1].q   = {r_st[k].q[W-2:0], 1'b0};
            end
        end
        // sign and saturation
        qf = r_st[DivSteps].q;
        n_quo.f = 1'b0;
        n_quo.v = $signed(qf);
        if (r_st[DivSteps].den0) begin
            n_quo.f = 1'b1;
            n_quo.v = r_st[DivSteps].npos ? SMax : (r_st[DivSteps].nneg ? SMin : '0);
        end else if (r_st[DivSteps].big) begin
            n_quo.f = 1'b1;
            n_quo.v = r_st[DivSteps].neg ? SMin : SMax;
        end else if (r_st[DivSteps].neg) begin
            if (qf > W'(SMin)) begin
                n_quo.f = 1'b1;
                n_quo.v = SMin;
            end else begin
                n_quo.v = $signed(W'(-qf));
            end
        end else if (qf[W-1]) begin
            n_quo.f = 1'b1;
            n_quo.v = SMax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k <= DivSteps; k++) begin
                r_st[k] <= n_st[k];
            end
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

// ===== test/axisymmetric_flow_source_term_unit_tb.sv =====
module axisymmetric_flow_source_term_unit_tb;
    import afst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdlePct  = 34;
    localparam int QuietMax = 5000;
    localparam int DrainGap = 100;
    localparam longint QMax = 64'sd2147483647;
    localparam longint QMin = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] rho;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] en;
        logic signed [31:0] r;
        logic [30:0]        vol;
    } cell_t;

    typedef struct {
        logic [1:0]         row;
        logic signed [31:0] res;
        logic signed [31:0] jac [4];
        logic               sat;
        logic               last;
    } row_t;

    // predicts the four source rows of a cell and checks them as they leave
    class source_rows_board;
        longint gam;
        bit     imp;
        longint thr;
        row_t   rows_due [$];
        int     mismatches;
        int     rows_seen;
        int     cells_seen;

        function new();
            gam = 91750;
            imp = 0;
            thr = 0;
        endfunction

        function longint clamp(longint x, inout bit f);
            if (x > QMax) begin
                f = 1;
                return QMax;
            end
            if (x < QMin) begin
                f = 1;
                return QMin;
            end
            return x;
        endfunction

        function longint fmul(longint a, longint b, inout bit f);
            longint p;
            p = a * b;
            return clamp(p >>> 16, f);
        endfunction

        function longint fdiv(longint a, longint b, inout bit f);
            if (b == 0) begin
                f = 1;
                return (a > 0) ? QMax : (a < 0) ? QMin : 0;
            end
            return clamp((a * 65536) / b, f);
        endfunction

        // note an accepted cell: queue its four expected rows
        function void note_cell(cell_t c);
            longint rho, mx, my, en, r, vol, gm1, s, u, v, p, h, t, e, q, vv;
            longint res [4];
            longint jac [4][4];
            bit f0, f1, f2, f3, fs, fu, fv;
            row_t w;
            rho = longint'(c.rho); mx = longint'(c.mx); my = longint'(c.my);
            en = longint'(c.en); r = longint'(c.r);
            vol = longint'(c.vol);
            f0 = 0; f1 = 0; f2 = 0; f3 = 0; fs = 0; fu = 0; fv = 0;
            foreach (res[k]) res[k] = 0;
            foreach (jac[k, j]) jac[k][j] = 0;
            cells_seen++;
            if (r > thr) begin
                gm1 = gam - 65536;
                s = fdiv(vol, r, fs);
                u = fdiv(mx, rho, fu);
                v = fdiv(my, rho, fv);
                res[0] = fmul(s, my, f0);
                res[1] = fmul(s, fmul(mx, v, f1), f1);
                res[2] = fmul(s, fmul(my, v, f2), f2);
                t = clamp(fmul(mx, u, f3) + fmul(my, v, f3), f3);
                p = fmul(gm1, clamp(en - fmul(32768, t, f3), f3), f3);
                h = fdiv(clamp(en + p, f3), rho, f3);
                res[3] = fmul(s, fmul(h, my, f3), f3);
                f0 |= fs;
                f1 |= fs | fv;
                f2 |= fs | fv;
                f3 |= fs | fu | fv;
                if (imp) begin
                    jac[0][2] = 65536;
                    jac[1][0] = clamp(-fmul(u, v, f1), f1);
                    jac[1][1] = v;
                    jac[1][2] = u;
                    f1 |= fu;
                    vv = fmul(v, v, f2);
                    jac[2][0] = clamp(-vv, f2);
                    jac[2][2] = fmul(131072, v, f2);
                    e = fdiv(en, rho, f3);
                    q = clamp(fmul(u, u, f3) + fmul(v, v, f3), f3);
                    jac[3][0] = clamp(clamp(-fmul(gam, fmul(v, e, f3), f3), f3)
                                      + fmul(gm1, fmul(v, q, f3), f3), f3);
                    jac[3][1] = clamp(-fmul(gm1, fmul(u, v, f3), f3), f3);
                    t = clamp(q + fmul(131072, fmul(v, v, f3), f3), f3);
                    jac[3][2] = clamp(fmul(gam, e, f3)
                                      - fmul(32768, fmul(gm1, t, f3), f3), f3);
                    jac[3][3] = fmul(gam, v, f3);
                    for (int j = 0; j < 4; j++) begin
                        jac[0][j] = fmul(jac[0][j], s, f0);
                        jac[1][j] = fmul(jac[1][j], s, f1);
                        jac[2][j] = fmul(jac[2][j], s, f2);
                        jac[3][j] = fmul(jac[3][j], s, f3);
                    end
                end
            end
            for (int k = 0; k < 4; k++) begin
                w.row  = k[1:0];
                w.res  = res[k][31:0];
                for (int j = 0; j < 4; j++) w.jac[j] = jac[k][j][31:0];
                w.sat  = (k == 0) ? f0 : (k == 1) ? f1 : (k == 2) ? f2 : f3;
                w.last = (k == 3);
                rows_due.push_back(w);
            end
        endfunction

        // compare one leaving row with the oldest expected row
        function void check_row(row_t a);
            row_t x;
            bit bad;
            rows_seen++;
            if (rows_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row %0d res %h", a.row, a.res);
                return;
            end
            x = rows_due.pop_front();
            bad = (a.row !== x.row) || (a.res !== x.res) || (a.sat !== x.sat)
                  || (a.last !== x.last);
            for (int j = 0; j < 4; j++) bad |= (a.jac[j] !== x.jac[j]);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("row mismatch: exp row %0d res %h jac %h %h %h %h sat %b last %b",
                             x.row, x.res, x.jac[0], x.jac[1], x.jac[2], x.jac[3],
                             x.sat, x.last);
                    $display("              got row %0d res %h jac %h %h %h %h sat %b last %b",
                             a.row, a.res, a.jac[0], a.jac[1], a.jac[2], a.jac[3],
                             a.sat, a.last);
                end
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    t_cfg_idx            i_cfg_idx;
    logic [GammaW-1:0]   i_cfg_data;
    logic                i_valid;
    logic                o_stall;
    logic signed [W-1:0] i_density;
    logic signed [W-1:0] i_momentum_x;
    logic signed [W-1:0] i_momentum_y;
    logic signed [W-1:0] i_total_energy;
    logic signed [W-1:0] i_radial_coord;
    logic [W-2:0]        i_cell_volume;
    logic                o_valid;
    logic                i_stall;
    logic [1:0]          o_row_index;
    logic signed [W-1:0] o_residual;
    logic signed [W-1:0] o_jac_col0;
    logic signed [W-1:0] o_jac_col1;
    logic signed [W-1:0] o_jac_col2;
    logic signed [W-1:0] o_jac_col3;
    logic                o_saturated;
    logic                o_last_row;

    axisymmetric_flow_source_term_unit dut (.*);

    source_rows_board board = new();
    bit calm;
    int hold_cycles;
    int quiet;
    int cfg_writes;

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CfgGamma;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_density      = '0;
        i_momentum_x   = '0;
        i_momentum_y   = '0;
        i_total_energy = '0;
        i_radial_coord = '0;
        i_cell_volume  = '0;
        i_stall        = 1'b0;
    end

    // receiver: random stall, long hold-off on request, check each accepted row
    always @(posedge i_clk) begin
        row_t a;
        if (i_rst_n && o_valid && !i_stall) begin
            a.row  = o_row_index;
            a.res  = o_residual;
            a.jac[0] = o_jac_col0;
            a.jac[1] = o_jac_col1;
            a.jac[2] = o_jac_col2;
            a.jac[3] = o_jac_col3;
            a.sat  = o_saturated;
            a.last = o_last_row;
            board.check_row(a);
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < IdlePct);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet > QuietMax) begin
            $display("watchdog expired");
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one register write; the caller drops the write enable after the last one
    task automatic cfg_write(t_cfg_idx idx, logic [GammaW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CfgGamma:    board.gam = longint'(data);
            CfgImplicit: board.imp = data[0];
            default:     board.thr = longint'(data[ThrW-1:0]);
        endcase
        cfg_writes++;
    endtask

    task automatic drain();
        while (board.rows_due.size() != 0) @(posedge i_clk);
        repeat (DrainGap) @(posedge i_clk);
    endtask

    task automatic reconfigure(logic [GammaW-1:0] g, logic imp, logic [GammaW-1:0] thr);
        i_valid <= 1'b0;
        drain();
        cfg_write(CfgGamma, g);
        cfg_write(CfgImplicit, {18'd0, imp});
        cfg_write(CfgAxisThr, thr);
        i_cfg_we <= 1'b0;
    endtask

    // offer one cell until accepted, then maybe pause
    task automatic send_cell(cell_t c);
        i_valid        <= 1'b1;
        i_density      <= c.rho;
        i_momentum_x   <= c.mx;
        i_momentum_y   <= c.my;
        i_total_energy <= c.en;
        i_radial_coord <= c.r;
        i_cell_volume  <= c.vol;
        do @(posedge i_clk); while (o_stall);
        board.note_cell(c);
        if (!calm && $urandom_range(99) < IdlePct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic cell_t mk(int rho, int mx, int my, int en, int r, int vol);
        cell_t c;
        c.rho = rho; c.mx = mx; c.my = my; c.en = en; c.r = r; c.vol = vol[30:0];
        return c;
    endfunction

    // mostly physical cells, some zero density, some raw bit patterns
    function automatic cell_t random_cell();
        cell_t c;
        int pick;
        pick = $urandom_range(99);
        if (pick < 20) begin
            c.rho = $urandom; c.mx = $urandom; c.my = $urandom;
            c.en = $urandom; c.r = $urandom; c.vol = 31'($urandom);
            return c;
        end
        c.rho = (pick < 30) ? 0 : $urandom_range(32'h4000, 32'h40000);
        c.mx  = $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
        c.my  = $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
        c.en  = $urandom_range(32'h10000, 32'h100000);
        c.r   = (pick < 38) ? 32'(board.thr + longint'($urandom_range(0, 2)) - 1)
                            : $signed($urandom_range(0, 32'h40000)) - 32'sh4000;
        c.vol = 31'($urandom_range(0, 32'h40000));
        return c;
    endfunction

    task automatic random_run(int n);
        for (int k = 0; k < n; k++) send_cell(random_cell());
    endtask

    initial begin
        cell_t dir [$];
        calm = 0;
        hold_cycles = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration
        random_run(40);

        // implicit on, smallest gamma, threshold at one half
        reconfigure(19'd65536, 1'b1, 19'h8000);
        dir.push_back(mk(32'h10000, 32'h8000, 32'h4000, 32'h30000, 32'h20000, 32'h10000));
        dir.push_back(mk(0, 32'h8000, -32'h4000, 32'h30000, 32'h20000, 32'h10000));
        dir.push_back(mk(0, 0, 0, 0, 32'h20000, 32'h10000));
        dir.push_back(mk(32'h10000, 32'h8000, 32'h4000, 32'h30000, 32'h8000, 32'h10000));
        dir.push_back(mk(32'h10000, 32'h8000, 32'h4000, 32'h30000, 32'h8001, 32'h10000));
        dir.push_back(mk(32'h10000, 32'h8000, 32'h4000, 32'h30000, 0, 32'h10000));
        dir.push_back(mk(32'h10000, 32'h8000, 32'h4000, 32'h30000, 32'h80000000, 32'h10));
        dir.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                         32'h7fffffff, 32'h7fffffff));
        dir.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                         32'h7fffffff, 32'h7fffffff));
        dir.push_back(mk(32'h10000, 32'h20000, -32'h20000, -32'h50000, 32'h10000, 0));
        dir.push_back(mk(-32'h10000, 32'h20000, 32'h7fffffff, 32'h10000, 32'h10, 32'h7fffffff));
        dir.push_back(mk(32'h1, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000));
        foreach (dir[k]) send_cell(dir[k]);
        random_run(20);
        // receiver holds off while cells keep coming
        hold_cycles = 400;
        random_run(40);

        // largest gamma, largest threshold, with a stretch of no idling
        reconfigure(19'd262144, 1'b1, 19'd65536);
        calm = 1;
        random_run(30);
        calm = 0;
        random_run(30);

        // explicit mode, default gamma, zero threshold
        reconfigure(19'd91750, 1'b0, 19'd0);
        random_run(40);

        i_valid <= 1'b0;
        drain();
        $display("covered %0d cells and %0d rows over %0d register writes",
                 board.cells_seen, board.rows_seen, cfg_writes);
        $display("phases: reset defaults, implicit with gamma 1.0 and 4.0, explicit; %0d bad",
                 board.mismatches);
        if (board.mismatches == 0 && board.rows_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
